FILE: hdl/wua_pkg.sv
package wua_pkg;

    localparam int WIDTH_BYTES_DEF = 32;
    localparam int KIND_W          = 3;
    localparam int WORD_W          = 64;
    localparam int SHAMT_W         = 9;
    localparam int ORDER_W         = 2;
    localparam int BLEN_W          = 9;
    localparam int IN_DATA_W       = 528;  // 8*64 + 9 = 521, padded to bytes
    localparam int OUT_DATA_W      = 268;  // 256 + 2 + 9 + 1
    localparam int OUT_TDATA_W     = 272;

    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SHL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CMP  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BLEN = 3'd5;

    localparam logic [ORDER_W-1:0] ORDER_LT = 2'b11;
    localparam logic [ORDER_W-1:0] ORDER_EQ = 2'b00;
    localparam logic [ORDER_W-1:0] ORDER_GT = 2'b01;

endpackage

FILE: hdl/wide_unsigned_alu_256.sv
// Wide unsigned ALU: multiply (low half), divide (quotient), shifts,
// compare and bit length on 8*WIDTH_BYTES-bit operands.
// Input transaction on s_axis_*: tuser carries the operation kind, tdata the
// operands and shift count. One result transaction per input on m_axis_*.
// The core works one bit per cycle; multiply and divide share a single wide
// adder and step through every operand bit, a shift moves the value one bit
// per step up to its count (a count that reaches the width clears it), and
// compare and bit length make one full scan.
// s_axis_tready is high only while the core is idle and the output register
// is empty; no new transaction is taken while a result waits there.
// Reset (aresetn low, synchronous) drops any transaction in flight and
// empties the output register. A stalled receiver holds the result stable
// and keeps the input stalled until the result is taken.
module wide_unsigned_alu_256 #(
    parameter int WIDTH_BYTES = wua_pkg::WIDTH_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_word0..3, b_word0..3, shift_amount, zero pad
    input  logic [527:0] s_axis_tdata,
    // kind
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // r_word0..3, order, bit_length, div_by_zero, zero pad
    output logic [271:0] m_axis_tdata
);
    import wua_pkg::*;

    localparam int NBITS = 8 * WIDTH_BYTES;
    localparam int OPW   = (NBITS < 256) ? NBITS : 256;

    logic [NBITS-1:0] a_op, b_op, res;
    logic [ORDER_W-1:0] order;
    logic [BLEN_W-1:0]  blen;
    logic dz, done, busy_reg, start;

    always_comb begin
        a_op = '0;
        b_op = '0;
        a_op[OPW-1:0] = s_axis_tdata[OPW-1:0];
        b_op[OPW-1:0] = s_axis_tdata[256 +: OPW];
    end

    assign s_axis_tready = !busy_reg && !m_axis_tvalid;
    assign start = s_axis_tvalid && s_axis_tready;

    wua_core #(.NBITS(NBITS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .start(start), .kind(s_axis_tuser),
        .a_in(a_op), .b_in(b_op), .shamt(s_axis_tdata[520:512]),
        .done(done), .res(res), .order(order), .blen(blen), .dz(dz)
    );

    logic [255:0] r_wide;
    always_comb begin
        r_wide = '0;
        r_wide[OPW-1:0] = res[OPW-1:0];
    end

    // Hold result in output register until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (start) busy_reg <= 1'b1;
            if (done) begin
                busy_reg      <= 1'b0;
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {4'b0, dz, blen, order, r_wide};
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_axis_tready) else $error("accept while busy");
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> busy_reg) else $error("done without item");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
`endif

endmodule

FILE: hdl/wua_core.sv
// Shared add/subtract datapath with iteration sequencer.
module wua_core #(
    parameter int NBITS = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wua_pkg::KIND_W-1:0]    kind,
    input  logic [NBITS-1:0]              a_in,
    input  logic [NBITS-1:0]              b_in,
    input  logic [wua_pkg::SHAMT_W-1:0]   shamt,
    output logic                          done,
    output logic [NBITS-1:0]              res,
    output logic [wua_pkg::ORDER_W-1:0]   order,
    output logic [wua_pkg::BLEN_W-1:0]    blen,
    output logic                          dz
);
    import wua_pkg::*;

    localparam int CNT_W = $clog2(NBITS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                state_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [NBITS-1:0]      x_reg;      // multiplicand / dividend then quotient / shifting value
    logic [NBITS-1:0]      y_reg;      // multiplier / divisor
    logic [NBITS-1:0]      acc_reg;    // product / remainder
    logic [CNT_W-1:0]      cnt_reg;
    logic [ORDER_W-1:0]    order_reg;
    logic [BLEN_W-1:0]     blen_reg;
    logic                  dz_reg;

    // Shared wide adder: add for multiply, subtract for divide
    logic              sub_sel;
    logic [NBITS-1:0]  alu_a;
    logic [NBITS-1:0]  alu_b;
    logic [NBITS:0]    alu_sum;
    logic [NBITS:0]    rem_sh;     // remainder shifted with next dividend bit
    logic              shift_big;  // shift count reaches the operand width

    assign rem_sh  = {acc_reg, x_reg[NBITS-1]};
    assign sub_sel = (kind_reg != KIND_MUL);
    assign alu_a   = (kind_reg == KIND_MUL) ? acc_reg : rem_sh[NBITS-1:0];
    assign alu_b   = (kind_reg == KIND_MUL) ? x_reg   : y_reg;
    assign alu_sum = sub_sel ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});
    assign shift_big = ({1'b0, shamt} >= (SHAMT_W+1)'(NBITS));

    // Divide keeps remainder in acc_reg and builds quotient into x_reg bit 0
    logic div_ge;
    assign div_ge = rem_sh[NBITS] | ~alu_sum[NBITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        kind_reg  <= kind;
                        x_reg     <= a_in;
                        y_reg     <= b_in;
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(NBITS);
                        order_reg <= ORDER_EQ;
                        blen_reg  <= '0;
                        dz_reg    <= 1'b0;
                        state_reg <= ST_RUN;
                        if (kind == KIND_DIV && b_in == '0) begin
                            dz_reg    <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        if ((kind == KIND_SHL || kind == KIND_SHR) && shift_big) begin
                            x_reg <= '0;
                        end
                        // a shift by the full width or more clears the value at start and does no shift steps
                        if (kind == KIND_SHL || kind == KIND_SHR)
                            cnt_reg <= shift_big ? '0 : CNT_W'(shamt);
                        if (kind > KIND_BLEN)
                            state_reg <= ST_DONE;
                    end
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    unique case (kind_reg)
                        KIND_MUL: begin
                            // add-shift, LSB of y first
                            if (y_reg[0]) acc_reg <= alu_sum[NBITS-1:0];
                            x_reg <= x_reg << 1;
                            y_reg <= y_reg >> 1;
                        end
                        KIND_DIV: begin
                            acc_reg <= div_ge ? alu_sum[NBITS-1:0] : rem_sh[NBITS-1:0];
                            x_reg   <= {x_reg[NBITS-2:0], div_ge};
                        end
                        KIND_SHL: x_reg <= x_reg << 1;
                        KIND_SHR: x_reg <= x_reg >> 1;
                        KIND_CMP: begin
                            // MSB-first scan, one bit per cycle
                            if (order_reg == ORDER_EQ && x_reg[NBITS-1] != y_reg[NBITS-1])
                                order_reg <= x_reg[NBITS-1] ? ORDER_GT : ORDER_LT;
                            x_reg <= x_reg << 1;
                            y_reg <= y_reg << 1;
                        end
                        default: begin
                            if (blen_reg == '0 && x_reg[NBITS-1])
                                blen_reg <= BLEN_W'(cnt_reg);
                            x_reg <= x_reg << 1;
                        end
                    endcase
                    if (cnt_reg <= CNT_W'(1)) state_reg <= ST_DONE;
                    if (cnt_reg == '0) begin
                        cnt_reg   <= cnt_reg;
                        x_reg     <= x_reg;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done  = (state_reg == ST_DONE);
    assign res   = (kind_reg == KIND_MUL) ? acc_reg :
                   (kind_reg == KIND_DIV || kind_reg == KIND_SHL || kind_reg == KIND_SHR)
                   ? (dz_reg ? '0 : x_reg) : '0;
    assign order = (kind_reg == KIND_CMP)  ? order_reg : ORDER_EQ;
    assign blen  = (kind_reg == KIND_BLEN) ? blen_reg  : '0;
    assign dz    = (kind_reg == KIND_DIV)  ? dz_reg    : 1'b0;

endmodule

FILE: sim/tb_wide_unsigned_alu_256.sv
module tb_wide_unsigned_alu_256;
    timeunit 1ns;
    timeprecision 1ps;
    import wua_pkg::*;

    typedef struct {
        logic [2:0]   kind;
        logic [255:0] a;
        logic [255:0] b;
        logic [8:0]   shamt;
    } alu_op_t;

    typedef struct {
        logic [255:0] r;
        logic [1:0]   order;
        logic [8:0]   blen;
        logic         dz;
    } alu_res_t;

    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 600;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [527:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [271:0] m_axis_tdata;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       mismatch_count = 0;
    int       sent_count = 0;
    bit       in_accepted = 0;
    bit       quiet_sender = 0;
    bit       quiet_receiver = 0;
    bit       hold_receiver = 0;
    bit       pause_sender = 0;

    wide_unsigned_alu_256 u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int bit_len(logic [255:0] x);
        int n;
        n = 0;
        for (int i = 0; i < 256; i++) begin
            if (x[i]) n = i + 1;
        end
        return n;
    endfunction

    // Compute the expected ALU result for one operation
    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t     res;
        logic [255:0] rem;
        logic [256:0] trial;
        res = '{default: '0};
        case (op.kind)
            KIND_MUL: res.r = op.a * op.b;
            KIND_DIV: begin
                if (op.b == '0) begin
                    res.dz = 1'b1;
                end else begin
                    // restoring long division, MSB first
                    rem = '0;
                    for (int i = 255; i >= 0; i--) begin
                        trial = {rem, op.a[i]};
                        if (trial >= {1'b0, op.b}) begin
                            trial = trial - {1'b0, op.b};
                            res.r[i] = 1'b1;
                        end
                        rem = trial[255:0];
                    end
                end
            end
            KIND_SHL: res.r = (op.shamt >= 256) ? '0 : op.a << op.shamt;
            KIND_SHR: res.r = (op.shamt >= 256) ? '0 : op.a >> op.shamt;
            KIND_CMP: res.order = (op.a < op.b) ? ORDER_LT :
                                  (op.a > op.b) ? ORDER_GT : ORDER_EQ;
            KIND_BLEN: res.blen = 9'(bit_len(op.a));
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [255:0] rand_wide(int style);
        logic [255:0] v;
        int           nb;
        for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
        case (style)
            0: v = '0;
            1: v = '1;
            2: begin
                nb = $urandom_range(256, 1);
                v = v >> (256 - nb);
            end
            3: v = 256'(1) << $urandom_range(255, 0);
            4: v = v >> $urandom_range(255, 192);
            default: ;
        endcase
        return v;
    endfunction

    function automatic alu_op_t make_op(logic [2:0] kind, logic [255:0] a,
                                        logic [255:0] b, logic [8:0] shamt);
        alu_op_t op;
        op.kind = kind;
        op.a = a;
        op.b = b;
        op.shamt = shamt;
        return op;
    endfunction

    // Append one operation to the stimulus queue
    function automatic void add_op(alu_op_t op);
        pending_ops = {pending_ops, op};
    endfunction

    // Drive input transactions at the falling edge
    always @(negedge aclk) begin
        alu_op_t op;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_accepted) begin
            // hold the offered transaction
        end else if (pending_ops.size() > 0 && !pause_sender &&
                     (quiet_sender || $urandom_range(99, 0) >= 13)) begin
            op = pending_ops.pop_front();
            expected_results = {expected_results, alu_predict(op)};
            s_axis_tdata <= {7'b0, op.shamt, op.b, op.a};
            s_axis_tuser <= op.kind;
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Sample input handshakes at the rising edge
    always @(posedge aclk) begin
        in_accepted <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) sent_count <= sent_count + 1;
    end

    always @(negedge aclk) begin
        if (!aresetn || hold_receiver) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet_receiver || $urandom_range(99, 0) >= 13;
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        alu_res_t exp_res;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: %h", m_axis_tdata);
            end else begin
                exp_res = expected_results.pop_front();
                if (m_axis_tdata[255:0] !== exp_res.r ||
                    m_axis_tdata[257:256] !== exp_res.order ||
                    m_axis_tdata[266:258] !== exp_res.blen ||
                    m_axis_tdata[267] !== exp_res.dz) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp r=%h ord=%0d blen=%0d dz=%b",
                                  " got r=%h ord=%0d blen=%0d dz=%b"},
                                 exp_res.r, exp_res.order, exp_res.blen, exp_res.dz,
                                 m_axis_tdata[255:0], m_axis_tdata[257:256],
                                 m_axis_tdata[266:258], m_axis_tdata[267]);
                end
            end
        end
    end

    // Long receiver hold-off, counted in its own process
    initial begin
        wait (sent_count >= 300);
        @(negedge aclk);
        hold_receiver = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        @(negedge aclk);
        hold_receiver = 1'b0;
    end

    // Fill the stimulus queue and pace the phases
    initial begin
        logic [255:0] a;
        logic [255:0] b;
        logic [2:0]   kind;
        int           total;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed corners
        add_op(make_op(KIND_MUL, '1, '1, 0));
        add_op(make_op(KIND_MUL, '0, '1, 0));
        add_op(make_op(KIND_MUL, 256'(1) << 128, 256'(1) << 127, 0));
        add_op(make_op(KIND_DIV, '1, '0, 0));
        add_op(make_op(KIND_DIV, '0, '0, 0));
        add_op(make_op(KIND_DIV, '1, 256'(1), 0));
        add_op(make_op(KIND_DIV, '1, '1, 0));
        add_op(make_op(KIND_DIV, 256'(5), '1, 0));
        add_op(make_op(KIND_DIV, '0, 256'(3), 0));
        add_op(make_op(KIND_SHL, '1, '0, 0));
        add_op(make_op(KIND_SHL, '1, '0, 255));
        add_op(make_op(KIND_SHL, '1, '1, 256));
        add_op(make_op(KIND_SHL, '1, '0, 9'h1ff));
        add_op(make_op(KIND_SHR, '1, '0, 1));
        add_op(make_op(KIND_SHR, '1, '0, 256));
        add_op(make_op(KIND_SHR, '1, '0, 9'h1ff));
        add_op(make_op(KIND_CMP, '1, '1, 0));
        add_op(make_op(KIND_CMP, '0, '1, 0));
        add_op(make_op(KIND_CMP, '1, '0, 0));
        add_op(make_op(KIND_BLEN, '0, '0, 0));
        add_op(make_op(KIND_BLEN, '1, '0, 0));
        add_op(make_op(KIND_BLEN, 256'(1), '1, 0));
        add_op(make_op(3'd6, '1, '1, 9'h1ff));
        add_op(make_op(3'd7, '1, '1, 9'h1ff));

        // pause the sender until every result has come back
        wait (pending_ops.size() == 0);
        pause_sender = 1'b1;
        wait (expected_results.size() == 0 && !s_axis_tvalid);
        pause_sender = 1'b0;

        total = 1650;
        for (int i = 0; i < total; i++) begin
            // advance to a stretch with no idling in the middle
            if (i == 800) begin
                wait (pending_ops.size() == 0);
                quiet_sender = 1'b1;
                quiet_receiver = 1'b1;
            end
            if (i == 1000) begin
                wait (pending_ops.size() == 0);
                quiet_sender = 1'b0;
                quiet_receiver = 1'b0;
            end
            a = rand_wide($urandom_range(6, 0));
            b = rand_wide($urandom_range(6, 0));
            if ($urandom_range(7, 0) == 0) b = a;
            kind = ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5, 0));
            add_op(make_op(kind, a, b,
                ($urandom_range(3, 0) == 0) ? 9'($urandom_range(511, 0))
                                            : 9'($urandom_range(256, 0))));
            if (pending_ops.size() > 8) wait (pending_ops.size() <= 4);
        end

        wait (pending_ops.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/wua_pkg.sv
hdl/wua_core.sv
hdl/wide_unsigned_alu_256.sv
sim/tb_wide_unsigned_alu_256.sv
